// ===== design/cfd_pkg.sv =====
// Shared types and constants for the command frame deframer.
`timescale 1ns / 1ps

package cfd_pkg;

  localparam logic [2:0] KIND_LEN      = 3'd0;
  localparam logic [2:0] KIND_CMD      = 3'd1;
  localparam logic [2:0] KIND_COUNT    = 3'd2;
  localparam logic [2:0] KIND_ARG_LEN  = 3'd3;
  localparam logic [2:0] KIND_ARG_DATA = 3'd4;

  localparam logic [7:0] OP_SET_BYTE = 8'h01;
  localparam logic [7:0] OP_GET_BYTE = 8'h02;
  localparam logic [7:0] OP_DEL_BYTE = 8'h03;

  localparam logic [1:0] CMD_SET     = 2'd0;
  localparam logic [1:0] CMD_GET     = 2'd1;
  localparam logic [1:0] CMD_DEL     = 2'd2;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  localparam logic [16:0] BODY_MAX = 17'h1FFFF;

  typedef struct packed {
    logic [2:0] byte_kind;
    logic [7:0] byte_value;
    logic [1:0] command_code;
    logic [7:0] arg_count;
    logic [7:0] arg_index;
    logic       arg_done;
    logic       message_done;
    logic       length_mismatch;
  } result_t;

endpackage

// ===== design/command_frame_deframer_core.sv =====
// Top level of the command frame deframer: parser feeding a skid-buffered result register.
//
//   Channel | Direction | Handshake          | Payload
//   in      | input     | in_valid, in_stall | data_byte
//   out     | output    | out_valid, out_stall | byte_kind, byte_value, command_code,
//           |           |                    | arg_count, arg_index, arg_done,
//           |           |                    | message_done, length_mismatch
//
// Each input beat is parsed in the cycle it is accepted and its result is registered,
// in the result register or, under an output stall, in the skid stage; one byte can be
// taken every clock while input stall is low. Reset is synchronous; it returns the parser
// to the first length byte and empties the result register and skid stage. Input stall
// rises only when both the result register and the skid stage hold results.
`timescale 1ns / 1ps

module command_frame_deframer_core
  import cfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] byte_kind,
  output logic [7:0] byte_value,
  output logic [1:0] command_code,
  output logic [7:0] arg_count,
  output logic [7:0] arg_index,
  output logic       arg_done,
  output logic       message_done,
  output logic       length_mismatch
);

  logic    accept;
  logic    buf_full;
  result_t parsed;
  result_t held;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  cfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .result    (parsed)
  );

  cfd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (parsed),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (held)
  );

  assign byte_kind       = held.byte_kind;
  assign byte_value      = held.byte_value;
  assign command_code    = held.command_code;
  assign arg_count       = held.arg_count;
  assign arg_index       = held.arg_index;
  assign arg_done        = held.arg_done;
  assign message_done    = held.message_done;
  assign length_mismatch = held.length_mismatch;

endmodule

// ===== design/cfd_parser.sv =====
// Frame parser: parse state registers and the per-byte decode logic.
`timescale 1ns / 1ps

module cfd_parser
  import cfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  output result_t    result
);

  localparam logic [2:0] PH_LEN_HI  = 3'd0;
  localparam logic [2:0] PH_LEN_LO  = 3'd1;
  localparam logic [2:0] PH_CMD     = 3'd2;
  localparam logic [2:0] PH_COUNT   = 3'd3;
  localparam logic [2:0] PH_ALEN_HI = 3'd4;
  localparam logic [2:0] PH_ALEN_LO = 3'd5;
  localparam logic [2:0] PH_DATA    = 3'd6;

  logic [2:0]  parse_phase, parse_phase_next;
  logic [15:0] declared_length, declared_length_next;
  logic [1:0]  held_command, held_command_next;
  logic [7:0]  args_total, args_total_next;
  logic [7:0]  current_arg, current_arg_next;
  logic [7:0]  arg_length_high, arg_length_high_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [16:0] body_count, body_count_next;

  logic [16:0] body_inc;
  logic        body_mismatch;
  logic [8:0]  arg_plus_one;
  logic        last_arg;
  logic [15:0] arg_length;
  logic [15:0] left_dec;
  logic [1:0]  decoded_cmd;

  always_comb begin
    body_inc      = (body_count < BODY_MAX) ? body_count + 17'd1 : body_count;
    body_mismatch = (body_inc != {1'b0, declared_length});
    arg_plus_one  = {1'b0, current_arg} + 9'd1;
    last_arg      = (arg_plus_one >= {1'b0, args_total});
    arg_length    = {arg_length_high, data_byte};
    left_dec      = bytes_left - 16'd1;
    unique case (data_byte)
      OP_SET_BYTE: decoded_cmd = CMD_SET;
      OP_GET_BYTE: decoded_cmd = CMD_GET;
      OP_DEL_BYTE: decoded_cmd = CMD_DEL;
      default:     decoded_cmd = CMD_UNKNOWN;
    endcase
  end

  always_comb begin
    parse_phase_next     = parse_phase;
    declared_length_next = declared_length;
    held_command_next    = held_command;
    args_total_next      = args_total;
    current_arg_next     = current_arg;
    arg_length_high_next = arg_length_high;
    bytes_left_next      = bytes_left;
    body_count_next      = body_count;

    result                 = '0;
    result.byte_value      = data_byte;

    unique case (parse_phase)
      PH_LEN_LO: begin
        declared_length_next = {declared_length[15:8], data_byte};
        parse_phase_next     = PH_CMD;
      end
      PH_CMD: begin
        result.byte_kind    = KIND_CMD;
        body_count_next     = body_inc;
        held_command_next   = decoded_cmd;
        result.command_code = decoded_cmd;
        parse_phase_next    = PH_COUNT;
      end
      PH_COUNT: begin
        result.byte_kind    = KIND_COUNT;
        body_count_next     = body_inc;
        args_total_next     = data_byte;
        current_arg_next    = 8'd0;
        result.command_code = held_command;
        result.arg_count    = data_byte;
        if (data_byte == 8'd0) begin
          result.message_done    = 1'b1;
          result.length_mismatch = body_mismatch;
          parse_phase_next       = PH_LEN_HI;
        end else begin
          parse_phase_next = PH_ALEN_HI;
        end
      end
      PH_ALEN_HI: begin
        result.byte_kind     = KIND_ARG_LEN;
        body_count_next      = body_inc;
        arg_length_high_next = data_byte;
        result.command_code  = held_command;
        result.arg_count     = args_total;
        result.arg_index     = current_arg;
        parse_phase_next     = PH_ALEN_LO;
      end
      PH_ALEN_LO: begin
        result.byte_kind    = KIND_ARG_LEN;
        body_count_next     = body_inc;
        result.command_code = held_command;
        result.arg_count    = args_total;
        result.arg_index    = current_arg;
        bytes_left_next     = arg_length;
        if (arg_length == 16'd0) begin
          result.arg_done = 1'b1;
          if (last_arg) begin
            result.message_done    = 1'b1;
            result.length_mismatch = body_mismatch;
            parse_phase_next       = PH_LEN_HI;
          end else begin
            current_arg_next = arg_plus_one[7:0];
            parse_phase_next = PH_ALEN_HI;
          end
        end else begin
          parse_phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        result.byte_kind    = KIND_ARG_DATA;
        body_count_next     = body_inc;
        result.command_code = held_command;
        result.arg_count    = args_total;
        result.arg_index    = current_arg;
        bytes_left_next     = left_dec;
        if (left_dec == 16'd0) begin
          result.arg_done = 1'b1;
          if (last_arg) begin
            result.message_done    = 1'b1;
            result.length_mismatch = body_mismatch;
            parse_phase_next       = PH_LEN_HI;
          end else begin
            current_arg_next = arg_plus_one[7:0];
            parse_phase_next = PH_ALEN_HI;
          end
        end
      end
      default: begin
        result.byte_kind     = KIND_LEN;
        declared_length_next = {data_byte, 8'h00};
        body_count_next      = '0;
        parse_phase_next     = PH_LEN_LO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_LEN_HI;
      declared_length <= '0;
      held_command    <= '0;
      args_total      <= '0;
      current_arg     <= '0;
      arg_length_high <= '0;
      bytes_left      <= '0;
      body_count      <= '0;
    end else if (accept) begin
      parse_phase     <= parse_phase_next;
      declared_length <= declared_length_next;
      held_command    <= held_command_next;
      args_total      <= args_total_next;
      current_arg     <= current_arg_next;
      arg_length_high <= arg_length_high_next;
      bytes_left      <= bytes_left_next;
      body_count      <= body_count_next;
    end
  end

endmodule

// ===== design/cfd_out_buf.sv =====
// Result register with a skid stage so that an input beat can still be taken under a stall.
`timescale 1ns / 1ps

module cfd_out_buf
  import cfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign full = skid_valid;
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule
